// ----- rtl/twes_pkg.sv -----
// Shared types and constants for the tower window energy sum block.
package twes_pkg;

	localparam int NUM_SIZES = 5;
	localparam int ENERGY_W  = 16;
	localparam int SUM_W     = 21;
	localparam int SHELL_W   = 3;
	localparam int POS_W     = 4;
	localparam int OFS_W     = 3;
	localparam int ETA_W     = 7;
	localparam int PHI_W     = 8;
	localparam int ETA_CNT_W = 8;
	localparam int PHI_CNT_W = 9;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 1;
	localparam int CMD_W     = 2;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EOF   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_PHI_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ETA_COUNT = 1'd1;

	localparam logic [PHI_CNT_W-1:0] PHI_COUNT_RST = 9'd256;
	localparam logic [ETA_CNT_W-1:0] ETA_COUNT_RST = 8'd96;

	typedef logic [SUM_W-1:0] sum_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH,
		ST_EOF,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic               valid;
		logic               use_tower;
		logic               shell_end;
		logic [SHELL_W-1:0] shell;
	} step_t;

	typedef struct packed {
		logic  clear_sums;
		logic  clear_peaks;
		step_t step;
	} acc_ctrl_t;

endpackage

// ----- rtl/twes_window_acc.sv -----
// Shell accumulator: running window sum, per-size sums and per-size peaks.
module twes_window_acc (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  twes_pkg::acc_ctrl_t                   ctrl,
	input  logic [twes_pkg::ENERGY_W-1:0]         rd_data,
	output twes_pkg::sum_t [twes_pkg::NUM_SIZES-1:0] sums,
	output twes_pkg::sum_t [twes_pkg::NUM_SIZES-1:0] peaks
);
	import twes_pkg::*;

	sum_t                  acc_q;
	sum_t [NUM_SIZES-1:0]  sum_q;
	sum_t [NUM_SIZES-1:0]  peak_q;
	sum_t                  acc_add;

	assign acc_add = acc_q + (ctrl.step.use_tower ? SUM_W'(rd_data) : '0);

	always_ff @(posedge clk) begin
		if (ctrl.clear_sums) begin
			acc_q <= '0;
			sum_q <= '0;
		end else if (ctrl.step.valid) begin
			acc_q <= acc_add;
			if (ctrl.step.shell_end) begin
				sum_q[ctrl.step.shell] <= acc_add;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (ctrl.clear_peaks) begin
			peak_q <= '0;
		end else if (ctrl.step.valid && ctrl.step.shell_end) begin
			if (acc_add > peak_q[ctrl.step.shell]) begin
				peak_q[ctrl.step.shell] <= acc_add;
			end
		end
	end

	assign sums  = sum_q;
	assign peaks = peak_q;

endmodule

// ----- rtl/tower_window_energy_sum_top.sv -----
// Top level of the tower window energy sum block: tower store, sequencer, output register.
//
// A write item leaves the block ready for the next item. A query walks the window in square
// shells, reading one tower per cycle from the single read port of the tower memory, over
// S shells with S = min(WINDOW_MAX, 5); an anchor outside the grid skips the walk. An
// end-of-frame item, and reset, start a clearing pass that writes one tower per cycle over
// all ETA_MAX*PHI_MAX towers (32768 at the defaults), during which in_ready stays low.
// Configuration writes are taken at any time. A result waits in the output register while
// the next item is accepted.
module tower_window_energy_sum_top #(
	parameter int PHI_MAX    = 256,
	parameter int ETA_MAX    = 128,
	parameter int WINDOW_MAX = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [twes_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [twes_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [twes_pkg::CMD_W-1:0]          cmd,
	input  logic [twes_pkg::ETA_W-1:0]          eta_index,
	input  logic [twes_pkg::PHI_W-1:0]          phi_index,
	input  logic [twes_pkg::ENERGY_W-1:0]       energy_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [15:0]                         sum_size1,
	output logic [17:0]                         sum_size2,
	output logic [19:0]                         sum_size3,
	output logic [19:0]                         sum_size4,
	output logic [20:0]                         sum_size5,
	output logic [15:0]                         peak_size1,
	output logic [17:0]                         peak_size2,
	output logic [19:0]                         peak_size3,
	output logic [19:0]                         peak_size4,
	output logic [20:0]                         peak_size5
);
	import twes_pkg::*;

	localparam int DEPTH = ETA_MAX * PHI_MAX;
	localparam int AW    = $clog2(DEPTH);
	localparam int WIN_N = (WINDOW_MAX < NUM_SIZES) ? WINDOW_MAX : NUM_SIZES;
	localparam logic [SHELL_W-1:0] LAST_SHELL = SHELL_W'(WIN_N - 1);

	state_t                 state_q, state_d;
	logic [SHELL_W-1:0]     shell_q, shell_d;
	logic [POS_W-1:0]       pos_q, pos_d;
	logic [AW-1:0]          clr_addr_q, clr_addr_d;
	logic [PHI_CNT_W-1:0]   phi_count_q;
	logic [ETA_CNT_W-1:0]   eta_count_q;
	logic [ETA_W-1:0]       eta_q;
	logic [PHI_W-1:0]       phi_q;
	logic [ETA_CNT_W-1:0]   ne_q, ne_c;
	logic [PHI_CNT_W-1:0]   np_q, np_c;
	logic                   inside_c;
	logic                   latch_anchor;
	logic                   load_query, load_eof;

	logic [OFS_W-1:0]       dp_c, de_c;
	logic [ETA_CNT_W-1:0]   et_c;
	logic [PHI_CNT_W-1:0]   ph_raw_c, ph_c;
	logic                   shell_end_c;
	step_t                  step_c, step_s1;
	acc_ctrl_t              acc_ctrl;

	logic [ENERGY_W-1:0]    tower_mem [DEPTH];
	logic [ENERGY_W-1:0]    rd_data_s1;
	logic [AW-1:0]          rd_addr_c, wr_addr_c, mem_waddr;
	logic [ENERGY_W-1:0]    mem_wdata;
	logic                   mem_we;
	logic                   wr_ok_c;

	sum_t [NUM_SIZES-1:0]   sums, peaks;
	sum_t [NUM_SIZES-1:0]   out_sum_q, out_peak_q;
	logic                   out_valid_q;
	logic                   slot_free;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phi_count_q <= PHI_COUNT_RST;
			eta_count_q <= ETA_COUNT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_PHI_COUNT: phi_count_q <= cfg_data;
				CFG_ETA_COUNT: eta_count_q <= cfg_data[ETA_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(eta_count_q) > ETA_MAX) ne_c = ETA_CNT_W'(ETA_MAX);
		else                            ne_c = eta_count_q;
		if (32'(phi_count_q) > PHI_MAX) np_c = PHI_CNT_W'(PHI_MAX);
		else                            np_c = phi_count_q;
	end

	assign inside_c = (ETA_CNT_W'(eta_index) < ne_c) && (PHI_CNT_W'(phi_index) < np_c);
	assign wr_ok_c  = (32'(eta_index) < ETA_MAX) && (32'(phi_index) < PHI_MAX);
	assign wr_addr_c = AW'(eta_index) * AW'(PHI_MAX) + AW'(phi_index);

	// shell walk: shell m covers (dp<m, de=m) then (dp=m, de=0..m)
	always_comb begin
		if (POS_W'(shell_q) > pos_q) begin
			dp_c = pos_q[OFS_W-1:0];
			de_c = shell_q;
		end else begin
			dp_c = shell_q;
			de_c = OFS_W'(pos_q - POS_W'(shell_q));
		end
		et_c     = ETA_CNT_W'(eta_q) + ETA_CNT_W'(de_c);
		ph_raw_c = PHI_CNT_W'(phi_q) + PHI_CNT_W'(dp_c);
		ph_c     = (ph_raw_c >= np_q) ? (ph_raw_c - np_q) : ph_raw_c;
	end

	assign shell_end_c = (pos_q == {shell_q, 1'b0});

	always_comb begin
		step_c.valid     = (state_q == ST_RUN);
		step_c.use_tower = (et_c < ne_q) && (ph_c < np_q);
		step_c.shell_end = shell_end_c;
		step_c.shell     = shell_q;
		rd_addr_c = step_c.use_tower ? (AW'(et_c) * AW'(PHI_MAX) + AW'(ph_c)) : '0;
	end

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d      = state_q;
		shell_d      = shell_q;
		pos_d        = pos_q;
		clr_addr_d   = clr_addr_q;
		latch_anchor = 1'b0;
		load_query   = 1'b0;
		load_eof     = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = wr_addr_c;
		mem_wdata    = energy_in;
		in_ready     = 1'b0;
		acc_ctrl.clear_sums  = 1'b0;
		acc_ctrl.clear_peaks = 1'b0;
		acc_ctrl.step        = step_s1;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (cmd)
						CMD_WRITE: mem_we = wr_ok_c;
						CMD_QUERY: begin
							latch_anchor        = 1'b1;
							acc_ctrl.clear_sums = 1'b1;
							shell_d             = '0;
							pos_d               = '0;
							state_d             = inside_c ? ST_RUN : ST_FINISH;
						end
						CMD_EOF: state_d = ST_EOF;
						default: ;
					endcase
				end
			end
			ST_RUN: begin
				if (shell_end_c) begin
					pos_d = '0;
					if (shell_q == LAST_SHELL) state_d = ST_DRAIN;
					else                       shell_d = shell_q + 1'b1;
				end else begin
					pos_d = pos_q + 1'b1;
				end
			end
			ST_DRAIN: state_d = ST_FINISH;
			ST_FINISH: begin
				if (slot_free) begin
					load_query = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_EOF: begin
				if (slot_free) begin
					load_eof             = 1'b1;
					acc_ctrl.clear_peaks = 1'b1;
					clr_addr_d           = '0;
					state_d              = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
				if (clr_addr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
				else                              clr_addr_d = clr_addr_q + 1'b1;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			shell_q     <= '0;
			pos_q       <= '0;
			clr_addr_q  <= '0;
			step_s1     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			shell_q    <= shell_d;
			pos_q      <= pos_d;
			clr_addr_q <= clr_addr_d;
			step_s1    <= step_c;
			if (load_query || load_eof) out_valid_q <= 1'b1;
			else if (out_ready)         out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (latch_anchor) begin
			eta_q <= eta_index;
			phi_q <= phi_index;
			ne_q  <= ne_c;
			np_q  <= np_c;
		end
		if (load_query || load_eof) begin
			for (int k = 0; k < NUM_SIZES; k++) begin
				out_sum_q[k]  <= load_eof ? '0 : sums[k];
				out_peak_q[k] <= peaks[k];
			end
		end
	end

	// tower store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tower_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= tower_mem[rd_addr_c];
	end

	twes_window_acc u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (acc_ctrl),
		.rd_data (rd_data_s1),
		.sums    (sums),
		.peaks   (peaks)
	);

	assign out_valid  = out_valid_q;
	assign sum_size1  = out_sum_q[0][15:0];
	assign sum_size2  = out_sum_q[1][17:0];
	assign sum_size3  = out_sum_q[2][19:0];
	assign sum_size4  = out_sum_q[3][19:0];
	assign sum_size5  = out_sum_q[4][20:0];
	assign peak_size1 = out_peak_q[0][15:0];
	assign peak_size2 = out_peak_q[1][17:0];
	assign peak_size3 = out_peak_q[2][19:0];
	assign peak_size4 = out_peak_q[3][19:0];
	assign peak_size5 = out_peak_q[4][20:0];

endmodule

// ----- verif/tb_tower_window_energy_sum_top.sv -----
// Testbench for the tower window energy sum block: directed and random items, checked by a scoreboard.
`timescale 1ns / 100ps

module tb_tower_window_energy_sum_top;
	import twes_pkg::*;

	localparam int ETA_SPAN       = 128;
	localparam int PHI_SPAN       = 256;
	localparam int WIN_LIMIT      = 5;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 150000;
	localparam int PHASE_ITEMS    = 118;
	localparam int EOF_BUDGET     = 6;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [NUM_SIZES-1:0][SUM_W-1:0] sums;
		logic [NUM_SIZES-1:0][SUM_W-1:0] peaks;
	} window_report_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [CMD_W-1:0]     cmd;
	logic [ETA_W-1:0]     eta_index;
	logic [PHI_W-1:0]     phi_index;
	logic [ENERGY_W-1:0]  energy_in;
	logic                 out_valid;
	logic                 out_ready;
	logic [15:0]          sum_size1;
	logic [17:0]          sum_size2;
	logic [19:0]          sum_size3;
	logic [19:0]          sum_size4;
	logic [20:0]          sum_size5;
	logic [15:0]          peak_size1;
	logic [17:0]          peak_size2;
	logic [19:0]          peak_size3;
	logic [19:0]          peak_size4;
	logic [20:0]          peak_size5;

	class window_sum_tracker;
		bit [15:0]      tower_mem [ETA_SPAN*PHI_SPAN];
		int unsigned    peak_hold [NUM_SIZES];
		int unsigned    phi_reg;
		int unsigned    eta_reg;
		int             sum_width [NUM_SIZES];
		window_report_t reports_due [$];
		int             mismatches;

		function new();
			foreach (tower_mem[i]) tower_mem[i] = '0;
			foreach (peak_hold[k]) peak_hold[k] = 0;
			phi_reg = 32'(PHI_COUNT_RST);
			eta_reg = 32'(ETA_COUNT_RST);
			sum_width = '{16, 18, 20, 20, 21};
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == CFG_PHI_COUNT)
				phi_reg = 32'(data);
			else if (idx == CFG_ETA_COUNT)
				eta_reg = 32'(data[ETA_CNT_W-1:0]);
		endfunction

		function int unsigned eta_used();
			return (eta_reg > ETA_SPAN) ? ETA_SPAN : eta_reg;
		endfunction

		function int unsigned phi_used();
			return (phi_reg > PHI_SPAN) ? PHI_SPAN : phi_reg;
		endfunction

		function int unsigned fit(int unsigned v, int w);
			return v & ((32'd1 << w) - 1);
		endfunction

		// phi wraps once; a tower still past the wrap point is dropped
		function int unsigned box_sum(int unsigned eta0, int unsigned phi0, int unsigned size,
				int unsigned ne, int unsigned np);
			int unsigned total;
			int unsigned ph;
			int unsigned et;
			total = 0;
			for (int dp = 0; dp < size; dp++) begin
				ph = phi0 + dp;
				if (ph >= np)
					ph -= np;
				if (ph < np) begin
					for (int de = 0; de < size; de++) begin
						et = eta0 + de;
						if (et < ne)
							total += 32'(tower_mem[et*PHI_SPAN + ph]);
					end
				end
			end
			return total;
		endfunction

		function void note_item(logic [CMD_W-1:0] op, logic [ETA_W-1:0] eta,
				logic [PHI_W-1:0] phi, logic [ENERGY_W-1:0] energy);
			window_report_t due;
			int unsigned    ne;
			int unsigned    np;
			int unsigned    s;
			bit             in_grid;
			due = '0;
			case (op)
				CMD_WRITE: begin
					tower_mem[int'(eta)*PHI_SPAN + int'(phi)] = energy;
				end
				CMD_QUERY: begin
					ne = eta_used();
					np = phi_used();
					in_grid = (32'(eta) < ne) && (32'(phi) < np);
					for (int k = 0; k < NUM_SIZES; k++) begin
						s = 0;
						if (in_grid && k + 1 <= WIN_LIMIT) begin
							s = fit(box_sum(32'(eta), 32'(phi), k + 1, ne, np), sum_width[k]);
							if (s > peak_hold[k])
								peak_hold[k] = s;
						end
						due.sums[k]  = SUM_W'(s);
						due.peaks[k] = SUM_W'(fit(peak_hold[k], sum_width[k]));
					end
					reports_due.push_back(due);
				end
				CMD_EOF: begin
					for (int k = 0; k < NUM_SIZES; k++) begin
						due.peaks[k] = SUM_W'(fit(peak_hold[k], sum_width[k]));
						peak_hold[k] = 0;
					end
					reports_due.push_back(due);
					foreach (tower_mem[i]) tower_mem[i] = '0;
				end
				default: ;
			endcase
		endfunction

		function void check_report(window_report_t got);
			window_report_t due;
			bit             bad;
			if (reports_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing expected", $realtime);
				return;
			end
			due = reports_due.pop_front();
			bad = 0;
			for (int k = 0; k < NUM_SIZES; k++)
				if (got.sums[k] !== due.sums[k] || got.peaks[k] !== due.peaks[k])
					bad = 1;
			if (!bad)
				return;
			mismatches++;
			if (mismatches > 10)
				return;
			for (int k = 0; k < NUM_SIZES; k++) begin
				if (got.sums[k] !== due.sums[k])
					$display("%0t: sum_size%0d expected %0d got %0d", $realtime, k + 1,
						due.sums[k], got.sums[k]);
				if (got.peaks[k] !== due.peaks[k])
					$display("%0t: peak_size%0d expected %0d got %0d", $realtime, k + 1,
						due.peaks[k], got.peaks[k]);
			end
		endfunction
	endclass

	window_sum_tracker tracker;
	window_report_t    seen;
	bit                steady;
	int                idle_cycles;
	int                stall_left;
	int                eof_left;

	tower_window_energy_sum_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.eta_index  (eta_index),
		.phi_index  (phi_index),
		.energy_in  (energy_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sum_size1  (sum_size1),
		.sum_size2  (sum_size2),
		.sum_size3  (sum_size3),
		.sum_size4  (sum_size4),
		.sum_size5  (sum_size5),
		.peak_size1 (peak_size1),
		.peak_size2 (peak_size2),
		.peak_size3 (peak_size3),
		.peak_size4 (peak_size4),
		.peak_size5 (peak_size5)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ENERGY_W-1:0] pick_energy();
		case ($urandom_range(0, 7))
			0: return '1;
			1: return '0;
			2: return ENERGY_W'($urandom_range(0, 255));
			default: return ENERGY_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// valid stays high from one item to the next unless a gap is drawn
	task automatic send_item(logic [CMD_W-1:0] op, logic [ETA_W-1:0] eta,
			logic [PHI_W-1:0] phi, logic [ENERGY_W-1:0] energy);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= op;
		eta_index <= eta;
		phi_index <= phi;
		energy_in <= energy;
		do @(posedge clk); while (!in_ready);
		tracker.note_item(op, eta, phi, energy);
	endtask

	task automatic settle_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.reports_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		tracker.set_reg(idx, data);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_grid(logic [CFG_W-1:0] phi_val, logic [CFG_W-1:0] eta_val);
		settle_block();
		if ($urandom_range(0, 1)) begin
			write_reg(CFG_PHI_COUNT, phi_val);
			write_reg(CFG_ETA_COUNT, eta_val);
		end else begin
			write_reg(CFG_ETA_COUNT, eta_val);
			write_reg(CFG_PHI_COUNT, phi_val);
		end
	endtask

	function automatic int unsigned edge_base(int unsigned used);
		case ($urandom_range(0, 2))
			0: return 0;
			1: return (used > 3) ? used - 3 : 0;
			default: return (used > 0) ? $urandom_range(0, used - 1) : 0;
		endcase
	endfunction

	// writes and queries cluster around a hot spot so windows see real data
	task automatic random_phase(int count);
		int unsigned         ne;
		int unsigned         np;
		int unsigned         be;
		int unsigned         bp;
		int                  r;
		logic [ETA_W-1:0]    eta;
		logic [PHI_W-1:0]    phi;
		ne = tracker.eta_used();
		np = tracker.phi_used();
		be = 0;
		bp = 0;
		for (int i = 0; i < count; i++) begin
			if (i % 30 == 0) begin
				be = edge_base(ne);
				bp = edge_base(np);
			end
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 4) == 0 || np == 0) begin
				eta = ETA_W'($urandom_range(0, ETA_SPAN - 1));
				phi = PHI_W'($urandom_range(0, PHI_SPAN - 1));
			end else if (r < 46) begin
				eta = ETA_W'(be + $urandom_range(0, 6));
				phi = PHI_W'((bp + $urandom_range(0, 6)) % np);
			end else begin
				eta = ETA_W'(be + $urandom_range(0, 4));
				phi = PHI_W'((bp + $urandom_range(0, 4)) % np);
			end
			if (r < 1 && eof_left > 0) begin
				eof_left--;
				send_item(CMD_EOF, eta, phi, pick_energy());
			end else if (r < 46) begin
				send_item(CMD_WRITE, eta, phi, pick_energy());
			end else if (r < 95) begin
				send_item(CMD_QUERY, eta, phi, pick_energy());
			end else begin
				send_item(CMD_UNUSED, eta, phi, pick_energy());
			end
		end
	endtask

	initial begin
		out_ready  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 9) < 3)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen = '0;
			seen.sums[0][15:0]  = sum_size1;
			seen.sums[1][17:0]  = sum_size2;
			seen.sums[2][19:0]  = sum_size3;
			seen.sums[3][19:0]  = sum_size4;
			seen.sums[4][20:0]  = sum_size5;
			seen.peaks[0][15:0] = peak_size1;
			seen.peaks[1][17:0] = peak_size2;
			seen.peaks[2][19:0] = peak_size3;
			seen.peaks[3][19:0] = peak_size4;
			seen.peaks[4][20:0] = peak_size5;
			tracker.check_report(seen);
		end
	end

	initial idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		logic [CFG_W-1:0] phase_phi [11];
		logic [CFG_W-1:0] phase_eta [11];
		phase_phi = '{9'd511, 9'd3, 9'd256, 9'd2, 9'd17, 9'd256, 9'd1, 9'd200, 9'd0, 9'd64,
			9'd130};
		phase_eta = '{9'd511, 9'd128, 9'd128, 9'd7, 9'd5, 9'd1, 9'd128, 9'd100, 9'd9, 9'd0,
			9'd255};
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		cmd       = CMD_WRITE;
		eta_index = '0;
		phi_index = '0;
		energy_in = '0;
		steady    = 1'b0;
		eof_left  = EOF_BUDGET;
		tracker   = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset grid: 256 phi, 96 eta
		send_item(CMD_QUERY, 7'd0, 8'd0, 16'hFFFF);
		send_item(CMD_WRITE, 7'd0, 8'd0, 16'hFFFF);
		send_item(CMD_WRITE, 7'd4, 8'd4, 16'hFFFF);
		send_item(CMD_WRITE, 7'd1, 8'd255, 16'hFFFF);
		send_item(CMD_WRITE, 7'd95, 8'd1, 16'h8000);
		send_item(CMD_WRITE, 7'd100, 8'd10, 16'hFFFF);
		send_item(CMD_QUERY, 7'd0, 8'd0, 16'h0000);
		send_item(CMD_QUERY, 7'd0, 8'd254, 16'h0000);
		send_item(CMD_QUERY, 7'd93, 8'd0, 16'h0000);
		send_item(CMD_QUERY, 7'd95, 8'd255, 16'h0000);
		send_item(CMD_QUERY, 7'd100, 8'd10, 16'h0000);
		send_item(CMD_QUERY, 7'd127, 8'd255, 16'hFFFF);
		send_item(CMD_UNUSED, 7'd127, 8'd255, 16'hFFFF);
		send_item(CMD_WRITE, 7'd4, 8'd4, 16'h0000);
		send_item(CMD_QUERY, 7'd0, 8'd0, 16'h0000);
		// tower stored outside the grid now comes into it
		set_grid(9'd256, 9'd128);
		send_item(CMD_QUERY, 7'd98, 8'd8, 16'h0000);
		send_item(CMD_WRITE, 7'd127, 8'd0, 16'hFFFF);
		send_item(CMD_QUERY, 7'd127, 8'd255, 16'h0000);
		// phi wrap point below the window size
		set_grid(9'd1, 9'd1);
		send_item(CMD_QUERY, 7'd0, 8'd0, 16'h0000);
		set_grid(9'd0, 9'd1);
		send_item(CMD_QUERY, 7'd0, 8'd0, 16'h0000);
		send_item(CMD_EOF, 7'd0, 8'd0, 16'h0000);
		set_grid(9'd256, 9'd96);
		send_item(CMD_QUERY, 7'd0, 8'd0, 16'h0000);
		send_item(CMD_EOF, 7'd127, 8'd255, 16'hFFFF);

		for (int p = 0; p < 11; p++) begin
			set_grid(phase_phi[p], phase_eta[p]);
			steady = (p % 4 == 2);
			random_phase(PHASE_ITEMS);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.reports_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.reports_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/twes_pkg.sv
rtl/twes_window_acc.sv
rtl/tower_window_energy_sum_top.sv
verif/tb_tower_window_energy_sum_top.sv
